FILE: rtl/core/alfd_pkg.sv
// ----------------------------------------------------------------------------
// alfd_pkg
// Shared types and constants for the alarm lamp frame decoder.
// ----------------------------------------------------------------------------
package alfd_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ROWS    = 4;
    localparam int unsigned LAMPS   = 4;
    localparam int unsigned ROW_W   = $clog2(ROWS);
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADDR  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_READ  = 3'd2,
        REQ_TICK  = 3'd3,
        REQ_SCAN  = 3'd4
    } req_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 1'd1;

    localparam logic [CFG_W-1:0] BLINK_OFF_RST    = 8'd44;
    localparam logic [CFG_W-1:0] BLINK_PERIOD_RST = 8'd66;

    // channel codes that touch the lamp store
    localparam logic [BYTE_W-1:0] CH_PROG   = 8'h08;
    localparam logic [BYTE_W-1:0] CH_STATUS = 8'h09;
    localparam logic [BYTE_W-1:0] CH_KEYREL = 8'h0B;
    localparam logic [3:0]        DIGIT_PAIR_MATCH = 4'd12;

    // lamps kept while blink phase is off
    localparam logic [LAMPS-1:0] ROW0_BLINK_MASK = 4'b0111;
    localparam logic [LAMPS-1:0] ROW1_BLINK_MASK = 4'b1110;

    typedef logic [ROWS-1:0][LAMPS-1:0] lamp_rows_t;

    // one transaction presented to the processing logic
    typedef struct packed {
        logic              fire;
        req_t              req;
        logic [BYTE_W-1:0] data;
    } step_t;

    typedef struct packed {
        logic                   wr_en;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_W-1:0]       wdata;
    } cfg_wr_t;

endpackage

FILE: rtl/core/alfd_frame.sv
// ----------------------------------------------------------------------------
// alfd_frame
// Bus frame assembly and alarm lamp store update.
// ----------------------------------------------------------------------------
module alfd_frame
    import alfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  step_t      step,
    output lamp_rows_t rows,
    output logic       frame_done
);

    logic [1:0]        idx_reg, idx_next;
    logic [BYTE_W-1:0] chan_reg, chan_next;
    logic [BYTE_W-1:0] high_reg, high_next;
    lamp_rows_t        rows_reg, rows_next;
    logic              done;

    always_comb begin
        idx_next  = idx_reg;
        chan_next = chan_reg;
        high_next = high_reg;
        rows_next = rows_reg;
        done      = 1'b0;
        case (step.req)
            REQ_ADDR: begin
                idx_next = 2'd0;
            end
            REQ_WRITE, REQ_READ: begin
                if (step.req == REQ_WRITE) begin
                    if (idx_reg == 2'd0) begin
                        chan_next = step.data;
                    end else if (idx_reg == 2'd1) begin
                        high_next = step.data;
                    end else if (idx_reg == 2'd2) begin
                        done = 1'b1;
                        if (chan_reg == CH_PROG) begin
                            if (high_reg[6:3] == DIGIT_PAIR_MATCH) begin
                                rows_next[0][1] = step.data[3];
                                rows_next[2][0] = step.data[5];
                                rows_next[2][3] = step.data[7];
                                rows_next[2][1] = high_reg[0];
                            end
                        end else if (chan_reg == CH_STATUS) begin
                            rows_next[3][3] = step.data[1];
                            rows_next[0][0] = step.data[2];
                            rows_next[1][3] = step.data[3];
                            rows_next[0][3] = step.data[4];
                            rows_next[1][0] = step.data[6];
                        end else if (chan_reg == CH_KEYREL) begin
                            rows_next[0][2] = high_reg[2];
                        end
                    end
                end
                // index saturates; only an address byte restarts the frame
                if (idx_reg != 2'd3) begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            chan_reg <= '0;
            high_reg <= '0;
            rows_reg <= '0;
        end else if (step.fire) begin
            idx_reg  <= idx_next;
            chan_reg <= chan_next;
            high_reg <= high_next;
            rows_reg <= rows_next;
        end
    end

    assign rows       = rows_next;
    assign frame_done = done;

`ifndef NO_ASSERTIONS
    a_rows_only_on_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !(step.fire && step.req == REQ_WRITE && idx_reg == 2'd2)
        |=> $stable(rows_reg))
        else $error("lamp store changed outside a frame end");
`endif

endmodule

FILE: rtl/core/alfd_blink.sv
// ----------------------------------------------------------------------------
// alfd_blink
// Blink settings registers, tick counter and blink phase.
// ----------------------------------------------------------------------------
module alfd_blink
    import alfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_wr_t cfg,
    input  step_t   step,
    output logic    phase,
    output logic    phase_next_o
);

    logic [CFG_W-1:0] off_cnt_reg;
    logic [CFG_W-1:0] period_cnt_reg;
    logic [CFG_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic             phase_reg, phase_next;

    always_comb begin
        cnt_inc    = cnt_reg + 8'd1;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (step.req == REQ_TICK) begin
            cnt_next = cnt_inc;
            // off test wins when both counts are equal
            if (cnt_inc == off_cnt_reg) begin
                phase_next = 1'b0;
            end else if (cnt_inc == period_cnt_reg) begin
                phase_next = 1'b1;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_cnt_reg    <= BLINK_OFF_RST;
            period_cnt_reg <= BLINK_PERIOD_RST;
            cnt_reg        <= '0;
            phase_reg      <= 1'b0;
        end else begin
            if (cfg.wr_en) begin
                case (cfg.index)
                    CFG_BLINK_OFF:    off_cnt_reg    <= cfg.wdata;
                    CFG_BLINK_PERIOD: period_cnt_reg <= cfg.wdata;
                    default: begin
                    end
                endcase
            end
            if (step.fire) begin
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
            end
        end
    end

    assign phase        = phase_reg;
    assign phase_next_o = phase_next;

endmodule

FILE: rtl/core/alfd_scan.sv
// ----------------------------------------------------------------------------
// alfd_scan
// Row scan sequencer with blink masking of the driven lamps.
// ----------------------------------------------------------------------------
module alfd_scan
    import alfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  step_t            step,
    input  lamp_rows_t       rows,
    input  logic             phase,
    output logic [ROW_W-1:0] row_sel_next,
    output logic [LAMPS-1:0] lamps_next
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [LAMPS-1:0] shown_reg, shown_next, masked;

    always_comb begin
        masked = rows[row_reg];
        if (!phase) begin
            if (row_reg == 2'd0) begin
                masked = masked & ROW0_BLINK_MASK;
            end else if (row_reg == 2'd1) begin
                masked = masked & ROW1_BLINK_MASK;
            end
        end
        row_next   = row_reg;
        shown_next = shown_reg;
        if (step.req == REQ_SCAN) begin
            row_next   = row_reg + 2'd1;
            shown_next = masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            shown_reg <= '0;
        end else if (step.fire) begin
            row_reg   <= row_next;
            shown_reg <= shown_next;
        end
    end

    // last driven row is one behind the next row to drive
    assign row_sel_next = row_next - 2'd1;
    assign lamps_next   = shown_next;

endmodule

FILE: rtl/core/alarm_lamp_frame_decoder.sv
// ----------------------------------------------------------------------------
// alarm_lamp_frame_decoder
// Decodes bus frames into a 4x4 alarm lamp store, blinks and scans it.
//
//   channel   direction  ports
//   s_        in         s_valid/s_ready, s_req_type, s_data_byte
//   m_        out        m_valid/m_ready, m_row_select, m_row_lamps,
//                        m_blink_on, m_frame_done
//   cfg_      in         cfg_wr_en, cfg_index, cfg_wdata
//
// One transaction per cycle unless a stalled result blocks the input;
// m_valid rises once a transaction has passed the input register and
// then the result register.
// Every transaction produces exactly one result.
// Synchronous active-low reset clears all but data registers; settings 44, 66.
// A stalled result holds the result register; the input register still
// takes one more transaction before s_ready drops.
// ----------------------------------------------------------------------------
module alarm_lamp_frame_decoder
    import alfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [REQ_W-1:0]     s_req_type,
    input  logic [BYTE_W-1:0]    s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ROW_W-1:0]     m_row_select,
    output logic [LAMPS-1:0]     m_row_lamps,
    output logic                 m_blink_on,
    output logic                 m_frame_done,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic              in_vld_reg;
    logic [REQ_W-1:0]  in_req_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              out_vld_reg;
    logic [ROW_W-1:0]  row_sel_reg;
    logic [LAMPS-1:0]  lamps_reg;
    logic              blink_reg;
    logic              done_reg;

    logic              advance;
    step_t             step;
    cfg_wr_t           cfg;
    lamp_rows_t        rows;
    logic              frame_done;
    logic              phase, phase_next;
    logic [ROW_W-1:0]  row_sel_next;
    logic [LAMPS-1:0]  lamps_next;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    assign step.fire = advance;
    assign step.req  = req_t'(in_req_reg);
    assign step.data = in_data_reg;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    alfd_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rows       (rows),
        .frame_done (frame_done)
    );

    alfd_blink u_blink (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .step         (step),
        .phase        (phase),
        .phase_next_o (phase_next)
    );

    // scan sees the store as it was before this transaction; scan never
    // coincides with a frame write, so the next-state view is equivalent
    alfd_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rows         (rows),
        .phase        (phase),
        .row_sel_next (row_sel_next),
        .lamps_next   (lamps_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= s_req_type;
            in_data_reg <= s_data_byte;
        end
        if (advance) begin
            row_sel_reg <= row_sel_next;
            lamps_reg   <= lamps_next;
            blink_reg   <= phase_next;
            done_reg    <= frame_done;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_row_select = row_sel_reg;
    assign m_row_lamps  = lamps_reg;
    assign m_blink_on   = blink_reg;
    assign m_frame_done = done_reg;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("processed transaction produced no result");

    a_phase_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !(advance && in_req_reg == REQ_TICK) |=> $stable(phase))
        else $error("blink phase moved without a tick");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the alarm lamp frame decoder. It drives bus events, timer
// ticks and scan steps with random idle and stall cycles, predicts each
// result from its own model of the frame, lamp store and blink logic, and
// compares every result field by field. It also sweeps the blink settings
// through several values, the largest value 255 among them.
// ----------------------------------------------------------------------------
module tb_top;
    import alfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [LAMPS-1:0] lamps;
        logic             blink;
        logic             done;
    } lamp_result_t;

    class lamp_decoder_scoreboard;
        logic [CFG_W-1:0]  off_count;
        logic [CFG_W-1:0]  period_count;
        logic [1:0]        byte_pos;
        logic [BYTE_W-1:0] channel;
        logic [BYTE_W-1:0] high;
        logic [LAMPS-1:0]  lamp_rows [ROWS];
        logic [7:0]        tick_count;
        logic              blink;
        logic [ROW_W-1:0]  scan_pos;
        logic [LAMPS-1:0]  shown;
        lamp_result_t      expected_results [$];
        int                errors;

        function new();
            off_count = BLINK_OFF_RST;
            period_count = BLINK_PERIOD_RST;
            byte_pos = '0;
            channel = '0;
            high = '0;
            foreach (lamp_rows[r]) lamp_rows[r] = '0;
            tick_count = '0;
            blink = 1'b0;
            scan_pos = '0;
            shown = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_BLINK_OFF) begin
                off_count = val;
            end else begin
                period_count = val;
            end
        endfunction

        function void apply_frame(logic [BYTE_W-1:0] low);
            if (channel == CH_PROG) begin
                if (high[6:3] == DIGIT_PAIR_MATCH) begin
                    lamp_rows[0][1] = low[3];
                    lamp_rows[2][0] = low[5];
                    lamp_rows[2][3] = low[7];
                    lamp_rows[2][1] = high[0];
                end
            end else if (channel == CH_STATUS) begin
                lamp_rows[3][3] = low[1];
                lamp_rows[0][0] = low[2];
                lamp_rows[1][3] = low[3];
                lamp_rows[0][3] = low[4];
                lamp_rows[1][0] = low[6];
            end else if (channel == CH_KEYREL) begin
                lamp_rows[0][2] = high[2];
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data);
            lamp_result_t res;
            logic [LAMPS-1:0] lamps;
            res.done = 1'b0;
            case (req)
                REQ_ADDR: byte_pos = '0;
                REQ_WRITE, REQ_READ: begin
                    if (req == REQ_WRITE) begin
                        if (byte_pos == 2'd0) begin
                            channel = data;
                        end else if (byte_pos == 2'd1) begin
                            high = data;
                        end else if (byte_pos == 2'd2) begin
                            apply_frame(data);
                            res.done = 1'b1;
                        end
                    end
                    // index sticks at 3 until the next address byte
                    if (byte_pos != 2'd3) byte_pos = byte_pos + 2'd1;
                end
                REQ_TICK: begin
                    tick_count = tick_count + 8'd1;
                    if (tick_count == off_count) begin
                        blink = 1'b0;
                    end else if (tick_count == period_count) begin
                        blink = 1'b1;
                        tick_count = '0;
                    end
                end
                REQ_SCAN: begin
                    lamps = lamp_rows[scan_pos];
                    if (!blink) begin
                        if (scan_pos == 2'd0) lamps = lamps & ROW0_BLINK_MASK;
                        else if (scan_pos == 2'd1) lamps = lamps & ROW1_BLINK_MASK;
                    end
                    shown = lamps;
                    scan_pos = scan_pos + 2'd1;
                end
                default: ;
            endcase
            res.row = scan_pos - 2'd1;
            res.lamps = shown;
            res.blink = blink;
            expected_results.push_back(res);
        endfunction

        function void check_result(lamp_result_t got);
            lamp_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result row %0d lamps %h blink %b done %b",
                         $time, got.row, got.lamps, got.blink, got.done);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.row !== want.row) begin
                $display("%0t: row_select expected %0d actual %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.lamps !== want.lamps) begin
                $display("%0t: row_lamps expected %h actual %h", $time, want.lamps, got.lamps);
                errors++;
            end
            if (got.blink !== want.blink) begin
                $display("%0t: blink_on expected %b actual %b", $time, want.blink, got.blink);
                errors++;
            end
            if (got.done !== want.done) begin
                $display("%0t: frame_done expected %b actual %b", $time, want.done, got.done);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type = '0;
    logic [BYTE_W-1:0]    s_data_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ROW_W-1:0]     m_row_select;
    logic [LAMPS-1:0]     m_row_lamps;
    logic                 m_blink_on;
    logic                 m_frame_done;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    lamp_decoder_scoreboard sb = new();
    bit idle_on = 1'b1;
    int items_sent = 0;
    int cycle_count = 0;

    alarm_lamp_frame_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_select (m_row_select),
        .m_row_lamps  (m_row_lamps),
        .m_blink_on   (m_blink_on),
        .m_frame_done (m_frame_done),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check on handshake, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_row_select, m_row_lamps, m_blink_on, m_frame_done});
        end
        m_ready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;
    end

    task automatic send_item(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data);
        // each idle cycle is drawn on its own, about 22 in a hundred
        while (idle_on && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req, data);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_blink_counts(logic [CFG_W-1:0] off_val, logic [CFG_W-1:0] period_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BLINK_OFF;
        cfg_wdata <= off_val;
        @(posedge aclk);
        cfg_index <= CFG_BLINK_PERIOD;
        cfg_wdata <= period_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(CFG_BLINK_OFF, off_val);
        sb.set_reg(CFG_BLINK_PERIOD, period_val);
    endtask

    function automatic logic [REQ_W-1:0] bus_op();
        return ($urandom_range(11) == 0) ? REQ_READ : REQ_WRITE;
    endfunction

    task automatic random_frame();
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] hi;
        int sel;
        sel = $urandom_range(9);
        ch = (sel < 3) ? CH_PROG : (sel < 6) ? CH_STATUS : (sel < 8) ? CH_KEYREL
                                                          : BYTE_W'($urandom_range(255));
        hi = BYTE_W'($urandom_range(255));
        if (ch == CH_PROG && $urandom_range(3) != 0) hi[6:3] = DIGIT_PAIR_MATCH;
        // now and then the address is missing and the frame runs on from a stale index
        if ($urandom_range(9) != 0) send_item(REQ_ADDR, BYTE_W'($urandom_range(255)));
        send_item(bus_op(), ch);
        send_item(bus_op(), hi);
        send_item(bus_op(), BYTE_W'($urandom_range(255)));
        if ($urandom_range(9) == 0) send_item(REQ_WRITE, BYTE_W'($urandom_range(255)));
    endtask

    task automatic random_phase(int n);
        int target;
        int pick;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                random_frame();
            end else if (pick < 65) begin
                repeat ($urandom_range(8, 1))
                    send_item(REQ_TICK, BYTE_W'($urandom_range(255)));
            end else if (pick < 85) begin
                repeat ($urandom_range(4, 1))
                    send_item(REQ_SCAN, BYTE_W'($urandom_range(255)));
            end else begin
                send_item(REQ_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing scanned yet
        send_item(REQ_ADDR, 8'hFF);
        send_item(REQ_SCAN, 8'h00);
        // channel 8 frame with matching digit pair, then a byte past the frame
        send_item(REQ_ADDR, 8'h00);
        send_item(REQ_WRITE, CH_PROG);
        send_item(REQ_WRITE, 8'h61);
        send_item(REQ_WRITE, 8'hA8);
        send_item(REQ_WRITE, 8'hFF);
        // channel 9 frame with a read in place of the high byte
        send_item(REQ_ADDR, 8'h55);
        send_item(REQ_WRITE, CH_STATUS);
        send_item(REQ_READ, 8'h33);
        send_item(REQ_WRITE, 8'h5E);
        // channel 11 frame
        send_item(REQ_ADDR, 8'h00);
        send_item(REQ_WRITE, CH_KEYREL);
        send_item(REQ_WRITE, 8'h04);
        send_item(REQ_WRITE, 8'hFF);
        // channel 8 without the digit pair, and unused request codes
        send_item(REQ_ADDR, 8'h00);
        send_item(REQ_WRITE, CH_PROG);
        send_item(REQ_WRITE, 8'hFF);
        send_item(REQ_WRITE, 8'hFF);
        send_item(3'd5, 8'hFF);
        send_item(3'd6, 8'h00);
        send_item(3'd7, 8'hAA);
        send_item(REQ_TICK, 8'h00);
        repeat (4) send_item(REQ_SCAN, 8'hFF);

        wait_for_results();
        write_blink_counts(8'd1, 8'd2);
        random_phase(100);

        wait_for_results();
        write_blink_counts(8'd255, 8'd255);
        random_phase(80);

        // stretch with no idling on either side; off count set above the period count
        wait_for_results();
        write_blink_counts(8'd3, 8'd2);
        idle_on = 1'b0;
        random_phase(100);
        idle_on = 1'b1;

        wait_for_results();
        write_blink_counts(8'd5, 8'd9);
        random_phase(120);

        wait_for_results();
        write_blink_counts(8'd1, 8'd255);
        random_phase(100);

        wait_for_results();
        write_blink_counts(BLINK_OFF_RST, BLINK_PERIOD_RST);
        random_phase(100);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
